// ===== rtl/vnm_pkg.sv =====
// Shared types and constants for the vector normalize/move pipeline.
package vnm_pkg;

	// Operation carried on the input tuser bit
	typedef enum logic {
		OP_NORMALIZE = 1'b0,
		OP_MOVE      = 1'b1
	} op_t;

	// Normalization: the larger magnitude is brought into [2^30, 2^31)
	localparam int TOP_EXP    = 30;
	localparam int NORM_STEPS = 5;
	localparam int MAG_BITS   = 31;

	// Square root: 64-bit radicand, 32 digit cells, 32-bit length
	localparam int ROOT_BITS  = 64;
	localparam int SQRT_STEPS = 32;
	localparam int LEN_BITS   = 32;

endpackage

// ===== rtl/vnm_norm_cell.sv =====
// Normalize cell: shifts both magnitudes left or right by one power-of-two step, or passes them unchanged.
module vnm_norm_cell #(
	parameter int MW = 49,
	parameter int SW = 101,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld,
	input  logic [MW-1:0] mx,
	input  logic [MW-1:0] my,
	input  logic [SW-1:0] side,
	output logic          vld_q,
	output logic [MW-1:0] mx_q,
	output logic [MW-1:0] my_q,
	output logic [SW-1:0] side_q
);

	localparam int SH = 1 << K;

	logic [MW-1:0] mm;
	logic [MW-1:0] mx_n;
	logic [MW-1:0] my_n;
	logic          go_right;
	logic          go_left;

	// pick the direction from the larger magnitude
	always_comb begin
		mm       = (mx > my) ? mx : my;
		go_right = (mm >> (vnm_pkg::TOP_EXP + SH)) != '0;
		go_left  = (mm >> (vnm_pkg::TOP_EXP + 1 - SH)) == '0;
		if (go_right) begin
			mx_n = mx >> SH;
			my_n = my >> SH;
		end else if (go_left) begin
			mx_n = mx << SH;
			my_n = my << SH;
		end else begin
			mx_n = mx;
			my_n = my;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_q   <= mx_n;
			my_q   <= my_n;
			side_q <= side;
		end
	end

endmodule

// ===== rtl/vnm_sqrt_cell.sv =====
// Square root cell: one result digit of the integer square root per cell.
module vnm_sqrt_cell #(
	parameter int SW = 163,
	parameter int I  = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld,
	input  logic [vnm_pkg::ROOT_BITS-1:0] n,
	input  logic [vnm_pkg::ROOT_BITS-1:0] r,
	input  logic [SW-1:0]                 side,
	output logic                          vld_q,
	output logic [vnm_pkg::ROOT_BITS-1:0] n_q,
	output logic [vnm_pkg::ROOT_BITS-1:0] r_q,
	output logic [SW-1:0]                 side_q
);

	localparam logic [vnm_pkg::ROOT_BITS-1:0] BIT =
		vnm_pkg::ROOT_BITS'(1) << (62 - 2 * I);

	logic [vnm_pkg::ROOT_BITS-1:0] t;
	logic [vnm_pkg::ROOT_BITS-1:0] n_n;
	logic [vnm_pkg::ROOT_BITS-1:0] r_n;
	logic                          ge;

	// trial subtract of r + bit
	always_comb begin
		t   = r + BIT;
		ge  = n >= t;
		n_n = ge ? (n - t) : n;
		r_n = ge ? ((r >> 1) + BIT) : (r >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q    <= n_n;
			r_q    <= r_n;
			side_q <= side;
		end
	end

endmodule

// ===== rtl/vnm_div_cell.sv =====
// Divide cell: one restoring quotient bit for the x and y lanes.
module vnm_div_cell #(
	parameter int W  = 32,
	parameter int SW = 69
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld,
	input  logic [vnm_pkg::LEN_BITS-1:0]      len,
	input  logic [1:0][vnm_pkg::LEN_BITS-1:0] rem,
	input  logic [1:0][W-1:0]                 nq,
	input  logic [SW-1:0]                     side,
	output logic                              vld_q,
	output logic [vnm_pkg::LEN_BITS-1:0]      len_q,
	output logic [1:0][vnm_pkg::LEN_BITS-1:0] rem_q,
	output logic [1:0][W-1:0]                 nq_q,
	output logic [SW-1:0]                     side_q
);

	logic [1:0][vnm_pkg::LEN_BITS-1:0] rem_n;
	logic [1:0][W-1:0]                 nq_n;

	// nq shifts numerator bits out at the top and quotient bits in at the bottom
	always_comb begin
		logic [vnm_pkg::LEN_BITS:0] r2;
		logic                       ge;
		for (int l = 0; l < 2; l++) begin
			r2       = {rem[l], nq[l][W-1]};
			ge       = r2 >= {1'b0, len};
			rem_n[l] = ge ? vnm_pkg::LEN_BITS'(r2 - {1'b0, len})
			              : r2[vnm_pkg::LEN_BITS-1:0];
			nq_n[l]  = {nq[l][W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_q  <= len;
			rem_q  <= rem_n;
			nq_q   <= nq_n;
			side_q <= side;
		end
	end

endmodule

// ===== rtl/vector_normalize_move.sv =====
// Top level: rescales a 2D vector or steps a point toward another, one item per cycle unless the row stalls.
//
//  channel   dir  tdata                          tuser
//  s_*       in   a_x, a_y, b_x, b_y, scale      opcode
//  m_*       out  out_x, out_y                   zero_length, saturated
//
// One item per cycle unless the row stalls on an unread result. Pipeline stages:
// front 1, normalize 5, squares 2, square root 32, products 2, divide WORD_BITS,
// round 1, output register 1. The 32-cell square root and the WORD_BITS-cell
// divider set the depth. Reset clears all valid flags. When a result sits in the
// output register unread, the row stalls only if its last stage holds an item.
module vector_normalize_move #(
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [((5*WORD_BITS+7)/8)*8-1:0] s_tdata,  // a_x, a_y, b_x, b_y, scale
	input  logic [0:0]                       s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata,  // out_x, out_y
	output logic [1:0]                       m_tuser   // zero_length, saturated
);

	localparam int W      = WORD_BITS;
	localparam int NW     = W + 1;
	localparam int MW     = (NW > vnm_pkg::MAG_BITS) ? NW : vnm_pkg::MAG_BITS;
	localparam int MB     = vnm_pkg::MAG_BITS;
	localparam int LB     = vnm_pkg::LEN_BITS;
	localparam int RB     = vnm_pkg::ROOT_BITS;
	localparam int CORE_W = 2 * W + 5;
	localparam int SIDE0  = CORE_W + W;
	localparam int SIDE1  = SIDE0 + 2 * MB;
	localparam int LO     = W / 2;
	localparam int HI     = W - LO;
	localparam int PW     = W + 30;
	localparam int ODW    = ((2 * W + 7) / 8) * 8;
	localparam int NS     = vnm_pkg::NORM_STEPS;
	localparam int QS     = vnm_pkg::SQRT_STEPS;

	logic en;
	logic vld_s6;

	// whole row moves unless a held result would be overwritten
	assign en       = !(m_tvalid && !m_tready && vld_s6);
	assign s_tready = en;

	// ---------------- front: direction, magnitudes, signs
	logic signed [W-1:0]  in_ax, in_ay, in_bx, in_by, in_s;
	logic signed [NW-1:0] dx, dy;
	logic [NW-1:0]        mdx, mdy;
	logic [W-1:0]         ms;
	logic                 op_move;

	always_comb begin
		in_ax   = s_tdata[W-1:0];
		in_ay   = s_tdata[2*W-1:W];
		in_bx   = s_tdata[3*W-1:2*W];
		in_by   = s_tdata[4*W-1:3*W];
		in_s    = s_tdata[5*W-1:4*W];
		op_move = vnm_pkg::op_t'(s_tuser[0]) == vnm_pkg::OP_MOVE;
		dx      = op_move ? (NW'(in_bx) - NW'(in_ax)) : NW'(in_ax);
		dy      = op_move ? (NW'(in_by) - NW'(in_ay)) : NW'(in_ay);
		mdx     = dx[NW-1] ? NW'(-dx) : NW'(dx);
		mdy     = dy[NW-1] ? NW'(-dy) : NW'(dy);
		ms      = in_s[W-1] ? W'(-in_s) : W'(in_s);
	end

	logic              vld_s1;
	logic [MW-1:0]     mx_s1, my_s1;
	logic [SIDE0-1:0]  side0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1    <= MW'(mdx);
			my_s1    <= MW'(mdy);
			side0_s1 <= {op_move, in_ax, in_ay, dx[NW-1], dy[NW-1], in_s[W-1],
			             (dx == '0) && (dy == '0), ms};
		end
	end

	// ---------------- normalize chain
	logic [NS:0]            nv;
	logic [NS:0][MW-1:0]    nmx, nmy;
	logic [NS:0][SIDE0-1:0] nside;

	assign nv[0]    = vld_s1;
	assign nmx[0]   = mx_s1;
	assign nmy[0]   = my_s1;
	assign nside[0] = side0_s1;

	for (genvar g = 0; g < NS; g++) begin : g_norm
		vnm_norm_cell #(.MW(MW), .SW(SIDE0), .K(NS - 1 - g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld    (nv[g]),
			.mx     (nmx[g]),
			.my     (nmy[g]),
			.side   (nside[g]),
			.vld_q  (nv[g+1]),
			.mx_q   (nmx[g+1]),
			.my_q   (nmy[g+1]),
			.side_q (nside[g+1])
		);
	end

	// ---------------- squares and their sum
	logic              vld_s2, vld_s3;
	logic [2*MB-1:0]   sqx_s2, sqy_s2;
	logic [SIDE1-1:0]  side1_s2, side1_s3;
	logic [RB-1:0]     n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= nv[NS];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= nmx[NS][MB-1:0] * nmx[NS][MB-1:0];
			sqy_s2   <= nmy[NS][MB-1:0] * nmy[NS][MB-1:0];
			side1_s2 <= {nside[NS], nmx[NS][MB-1:0], nmy[NS][MB-1:0]};
			n_s3     <= RB'(sqx_s2) + RB'(sqy_s2);
			side1_s3 <= side1_s2;
		end
	end

	// ---------------- square root chain
	logic [QS:0]            sv;
	logic [QS:0][RB-1:0]    sn, sr;
	logic [QS:0][SIDE1-1:0] sside;

	assign sv[0]    = vld_s3;
	assign sn[0]    = n_s3;
	assign sr[0]    = '0;
	assign sside[0] = side1_s3;

	for (genvar g = 0; g < QS; g++) begin : g_sqrt
		vnm_sqrt_cell #(.SW(SIDE1), .I(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld    (sv[g]),
			.n      (sn[g]),
			.r      (sr[g]),
			.side   (sside[g]),
			.vld_q  (sv[g+1]),
			.n_q    (sn[g+1]),
			.r_q    (sr[g+1]),
			.side_q (sside[g+1])
		);
	end

	// ---------------- magnitude times |scale|, in two partial products
	logic [MB-1:0]     pmx, pmy;
	logic [W-1:0]      pms;
	logic              vld_s4, vld_s5;
	logic [MB+LO-1:0]  plox_s4, ploy_s4;
	logic [MB+HI-1:0]  phix_s4, phiy_s4;
	logic [LB-1:0]     len_s4, len_s5;
	logic [CORE_W-1:0] core_s4, core_s5;
	logic [PW-1:0]     px_s5, py_s5;

	assign pmy = sside[QS][MB-1:0];
	assign pmx = sside[QS][2*MB-1:MB];
	assign pms = sside[QS][2*MB+W-1:2*MB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sv[QS];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plox_s4 <= pmx * pms[LO-1:0];
			ploy_s4 <= pmy * pms[LO-1:0];
			phix_s4 <= pmx * pms[W-1:LO];
			phiy_s4 <= pmy * pms[W-1:LO];
			len_s4  <= sr[QS][LB-1:0];
			core_s4 <= sside[QS][SIDE1-1:SIDE1-CORE_W];
			px_s5   <= PW'(plox_s4) + (PW'(phix_s4) << LO);
			py_s5   <= PW'(ploy_s4) + (PW'(phiy_s4) << LO);
			len_s5  <= len_s4;
			core_s5 <= core_s4;
		end
	end

	// ---------------- divide chain; the top 30 numerator bits never subtract
	logic [W:0]                  dv;
	logic [W:0][LB-1:0]          dlen;
	logic [W:0][1:0][LB-1:0]     drem;
	logic [W:0][1:0][W-1:0]      dnq;
	logic [W:0][CORE_W-1:0]      dside;

	assign dv[0]      = vld_s5;
	assign dlen[0]    = len_s5;
	assign drem[0][0] = LB'(px_s5[PW-1:W]);
	assign drem[0][1] = LB'(py_s5[PW-1:W]);
	assign dnq[0][0]  = px_s5[W-1:0];
	assign dnq[0][1]  = py_s5[W-1:0];
	assign dside[0]   = core_s5;

	for (genvar g = 0; g < W; g++) begin : g_div
		vnm_div_cell #(.W(W), .SW(CORE_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld    (dv[g]),
			.len    (dlen[g]),
			.rem    (drem[g]),
			.nq     (dnq[g]),
			.side   (dside[g]),
			.vld_q  (dv[g+1]),
			.len_q  (dlen[g+1]),
			.rem_q  (drem[g+1]),
			.nq_q   (dnq[g+1]),
			.side_q (dside[g+1])
		);
	end

	// ---------------- round to nearest, ties up
	logic [W:0]        qx_s6, qy_s6;
	logic [CORE_W-1:0] core_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= dv[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s6   <= (W+1)'(dnq[W][0]) +
			           (W+1)'({drem[W][0], 1'b0} >= {1'b0, dlen[W]});
			qy_s6   <= (W+1)'(dnq[W][1]) +
			           (W+1)'({drem[W][1], 1'b0} >= {1'b0, dlen[W]});
			core_s6 <= dside[W];
		end
	end

	// ---------------- sign, offset, clip
	logic                f_move, f_sx, f_sy, f_ss, f_zero;
	logic signed [W-1:0] f_ax, f_ay;
	logic signed [W+2:0] rx, ry;
	logic [W-1:0]        ox, oy;
	logic                sat_x, sat_y;

	always_comb begin
		f_move = core_s6[CORE_W-1];
		f_ax   = core_s6[CORE_W-2:W+4];
		f_ay   = core_s6[W+3:4];
		f_sx   = core_s6[3];
		f_sy   = core_s6[2];
		f_ss   = core_s6[1];
		f_zero = core_s6[0];
		rx     = (f_sx ^ f_ss) ? -(W+3)'(qx_s6) : (W+3)'(qx_s6);
		ry     = (f_sy ^ f_ss) ? -(W+3)'(qy_s6) : (W+3)'(qy_s6);
		if (f_move) begin
			rx = rx + (W+3)'(f_ax);
			ry = ry + (W+3)'(f_ay);
		end
		sat_x = rx[W+2] ? (rx[W+1:W-1] != '1) : (rx[W+1:W-1] != '0);
		sat_y = ry[W+2] ? (ry[W+1:W-1] != '1) : (ry[W+1:W-1] != '0);
		ox    = sat_x ? {rx[W+2], {(W-1){!rx[W+2]}}} : rx[W-1:0];
		oy    = sat_y ? {ry[W+2], {(W-1){!ry[W+2]}}} : ry[W-1:0];
		if (f_zero) begin
			ox    = f_move ? f_ax : '0;
			oy    = f_move ? f_ay : '0;
			sat_x = 1'b0;
			sat_y = 1'b0;
		end
	end

	// ---------------- output register; an unread result stays until taken
	logic [W-1:0] out_x_q, out_y_q;
	logic         zero_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s6 || (m_tvalid && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s6) begin
			out_x_q <= ox;
			out_y_q <= oy;
			zero_q  <= f_zero;
			sat_q   <= sat_x | sat_y;
		end
	end

	assign m_tdata = ODW'({out_y_q, out_x_q});
	assign m_tuser = {sat_q, zero_q};

endmodule

// ===== rtl/vnm_checker.sv =====
// Port checker for vector_normalize_move, bound to the top level.
module vnm_checker #(
	parameter int WORD_BITS = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata,
	input logic [1:0]                       m_tuser
);

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// a zero-length result is never flagged as clipped
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("zero_length and saturated both set");

	// input side never stalls while the sink takes items
	a_ready_sink: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output ready");

	// input side never stalls with an empty output register
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

endmodule

bind vector_normalize_move vnm_checker #(.WORD_BITS(WORD_BITS)) u_vnm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
